// ===== rtl/gb3_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gb3_pkg: shared definitions for the 3x3 Gaussian blur core
// Geometry limits, field widths, register map and the kernel sum.
// ----------------------------------------------------------------------------
package gb3_pkg;

    // Line store geometry
    localparam int MAX_WIDTH    = 2048;
    localparam int HEIGHT_LIMIT = 4096;
    localparam int COL_W        = $clog2(MAX_WIDTH);
    localparam int ROW_W        = $clog2(HEIGHT_LIMIT);

    // Field widths
    localparam int PIX_W   = 8;
    localparam int FW_W    = 12;
    localparam int FH_W    = 13;
    localparam int SUM_W   = PIX_W + 4;
    localparam int APB_DW  = 32;
    localparam int APB_AW  = 3;

    // Register map (index taken from paddr[2])
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    // Register reset values and clamp limits
    localparam logic [FW_W-1:0] FW_RESET = FW_W'(640);
    localparam logic [FH_W-1:0] FH_RESET = FH_W'(480);
    localparam logic [FW_W-1:0] FW_MIN   = FW_W'(3);
    localparam logic [FW_W-1:0] FW_MAX   = FW_W'(MAX_WIDTH);
    localparam logic [FH_W-1:0] FH_MIN   = FH_W'(3);
    localparam logic [FH_W-1:0] FH_MAX   = FH_W'(HEIGHT_LIMIT);

    typedef logic [PIX_W-1:0] pix_t;

    // Kernel 1-2-1 / 2-4-2 / 1-2-1 over one 3x3 neighborhood
    function automatic logic [SUM_W-1:0] kernel_sum(
        input pix_t l0, input pix_t l1, input pix_t l2,
        input pix_t c0, input pix_t c1, input pix_t c2,
        input pix_t r0, input pix_t r1, input pix_t r2
    );
        logic [SUM_W-1:0] s;
        s = SUM_W'(l0) + SUM_W'(l2) + SUM_W'(r0) + SUM_W'(r2)
          + (SUM_W'(l1) << 1) + (SUM_W'(c0) << 1)
          + (SUM_W'(c2) << 1) + (SUM_W'(r1) << 1)
          + (SUM_W'(c1) << 2);
        return s;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/gaussian_blur_3x3_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gaussian_blur_3x3_core: streaming 3x3 Gaussian filter on 8-bit luma
// Line-buffered 1-2-1 / 2-4-2 / 1-2-1 filter, sum truncated by 16.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter in raster order on the s_ request channel; s_frame_start
//   marks the first pixel of a frame and sets the position to row 0, col 0.
//   For each pixel at row r, column c with r >= 2 and c >= 2 one filtered
//   value for the center (r-1, c-1) leaves on the m_ channel with its
//   coordinates; m_last_of_frame flags the last interior pixel. Border
//   pixels are never produced.
//   On accept the line store read and the pixel enter the stage 1 registers;
//   the kernel result goes into the output register when stage 1 advances,
//   which a receiver stall can hold off. One pixel per clock while the
//   receiver does not stall, set by the separate read and write ports of
//   the two line stores.
//   A receiver stall holds the output register; pixels are still taken into
//   stage 1 until it holds one that produces a result, then s_ready drops.
//   Reset clears the position, the window and the handshakes and loads
//   frame_width 640, frame_height 480. Line store contents are not cleared.
//   The user must write frame_width (APB 0x0) and frame_height (APB 0x4) only while idle; not enforced.
// ----------------------------------------------------------------------------
module gaussian_blur_3x3_core (
    input  wire                          aclk,
    input  wire                          aresetn,
    // pixel input
    input  wire                          s_valid,
    output logic                         s_ready,
    input  wire  [gb3_pkg::PIX_W-1:0]    s_pixel,
    input  wire                          s_frame_start,
    // filtered output
    output logic                         m_valid,
    input  wire                          m_ready,
    output logic [gb3_pkg::PIX_W-1:0]    m_filtered,
    output logic [gb3_pkg::COL_W-1:0]    m_out_col,
    output logic [gb3_pkg::ROW_W-1:0]    m_out_row,
    output logic                         m_last_of_frame,
    // configuration
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire  [gb3_pkg::APB_AW-1:0]   paddr,
    input  wire  [gb3_pkg::APB_DW-1:0]   pwdata,
    output logic [gb3_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);
    import gb3_pkg::*;

    // Configuration registers
    logic [FW_W-1:0] frame_width_reg;
    logic [FH_W-1:0] frame_height_reg;
    logic [FW_W-1:0] w_eff;
    logic [FH_W-1:0] h_eff;

    // Position counters
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;

    // Stage 0 position decode
    logic [COL_W-1:0] start_col;
    logic [ROW_W-1:0] start_row;
    logic [FH_W-1:0]  wrap_row;
    logic [COL_W-1:0] pos_col;
    logic [ROW_W-1:0] pos_row;
    logic [FW_W-1:0]  inc_col;
    logic [FH_W-1:0]  inc_row;
    logic             pos_emit;
    logic             pos_last;
    logic             s_accept;

    // Stage 1 registers
    logic             s1_valid_reg;
    pix_t             s1_pixel_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic [ROW_W-1:0] s1_row_reg;
    logic             s1_emit_reg;
    logic             s1_last_reg;
    logic             s1_advance;
    logic             out_free;

    // Line stores and read path
    pix_t             upper_mem  [MAX_WIDTH];
    pix_t             middle_mem [MAX_WIDTH];
    pix_t             upper_rd_reg;
    pix_t             middle_rd_reg;
    logic             fwd_reg;
    pix_t             fwd_top_reg;
    pix_t             fwd_mid_reg;
    logic             fwd_next;
    pix_t             s1_top;
    pix_t             s1_mid;

    // Window: entries 0..2 column c-2, 3..5 column c-1 (top, middle, bottom)
    pix_t             win_reg [6];
    logic [SUM_W-1:0] sum;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= FW_RESET;
            frame_height_reg <= FH_RESET;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                REG_FRAME_WIDTH:  frame_width_reg  <= pwdata[FW_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= pwdata[FH_W-1:0];
                default: ;
            endcase
        end
    end

    // Return the addressed register
    always_comb begin
        unique case (paddr[2])
            REG_FRAME_WIDTH:  prdata = APB_DW'(frame_width_reg);
            REG_FRAME_HEIGHT: prdata = APB_DW'(frame_height_reg);
            default:          prdata = '0;
        endcase
    end

    // Clamp geometry to the supported range
    always_comb begin
        priority if (frame_width_reg < FW_MIN) w_eff = FW_MIN;
        else if (frame_width_reg > FW_MAX)     w_eff = FW_MAX;
        else                                   w_eff = frame_width_reg;
        priority if (frame_height_reg < FH_MIN) h_eff = FH_MIN;
        else if (frame_height_reg > FH_MAX)     h_eff = FH_MAX;
        else                                    h_eff = frame_height_reg;
    end

    // ------------------------------------------------------------------
    // Handshake control
    // ------------------------------------------------------------------
    assign out_free   = !m_valid || m_ready;
    assign s1_advance = s1_valid_reg && (!s1_emit_reg || out_free);
    assign s_ready    = !s1_valid_reg || s1_advance;
    assign s_accept   = s_valid && s_ready;

    // ------------------------------------------------------------------
    // Stage 0: resolve the position of the incoming pixel
    // ------------------------------------------------------------------
    always_comb begin
        start_col = s_frame_start ? '0 : col_reg;
        start_row = s_frame_start ? '0 : row_reg;

        // start a new line when the column ran past a shrunk width
        if (FW_W'(start_col) >= w_eff) begin
            pos_col  = '0;
            wrap_row = FH_W'(start_row) + FH_W'(1);
        end else begin
            pos_col  = start_col;
            wrap_row = FH_W'(start_row);
        end
        pos_row = (wrap_row >= h_eff) ? '0 : wrap_row[ROW_W-1:0];

        pos_emit = (pos_row >= ROW_W'(2)) && (pos_col >= COL_W'(2));
        pos_last = (FH_W'(pos_row) == h_eff - FH_W'(1))
                && (FW_W'(pos_col) == w_eff - FW_W'(1));

        // advance to the next position
        inc_col = FW_W'(pos_col) + FW_W'(1);
        inc_row = FH_W'(pos_row) + FH_W'(1);
        if (inc_col >= w_eff) begin
            col_next = '0;
            row_next = (inc_row >= h_eff) ? '0 : inc_row[ROW_W-1:0];
        end else begin
            col_next = inc_col[COL_W-1:0];
            row_next = pos_row;
        end

        // forward the line store write that lands on the address being read
        fwd_next = s1_advance && (s1_col_reg == pos_col);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (s_accept) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ------------------------------------------------------------------
    // Line stores: read on accept, write when stage 1 retires
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            upper_rd_reg  <= upper_mem[pos_col];
            middle_rd_reg <= middle_mem[pos_col];
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_advance) begin
            upper_mem[s1_col_reg]  <= s1_mid;
            middle_mem[s1_col_reg] <= s1_pixel_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            fwd_top_reg <= s1_mid;
            fwd_mid_reg <= s1_pixel_reg;
        end
    end

    assign s1_top = fwd_reg ? fwd_top_reg : upper_rd_reg;
    assign s1_mid = fwd_reg ? fwd_mid_reg : middle_rd_reg;

    // ------------------------------------------------------------------
    // Stage 1 registers: hold while the output is blocked
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
        end else if (s_accept) begin
            s1_valid_reg <= 1'b1;
            fwd_reg      <= fwd_next;
        end else if (s1_advance) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_pixel_reg <= s_pixel;
            s1_col_reg   <= pos_col;
            s1_row_reg   <= pos_row;
            s1_emit_reg  <= pos_emit;
            s1_last_reg  <= pos_last;
        end
    end

    // ------------------------------------------------------------------
    // Kernel and window shift
    // ------------------------------------------------------------------
    assign sum = kernel_sum(win_reg[0], win_reg[3], s1_top,
                            win_reg[1], win_reg[4], s1_mid,
                            win_reg[2], win_reg[5], s1_pixel_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 6; i++) begin
                win_reg[i] <= '0;
            end
        end else if (s1_advance) begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= s1_top;
            win_reg[4] <= s1_mid;
            win_reg[5] <= s1_pixel_reg;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (s1_advance && s1_emit_reg) begin
            m_valid <= 1'b1;
        end else if (m_ready) begin
            m_valid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_advance && s1_emit_reg) begin
            m_filtered      <= sum[SUM_W-1:4];
            m_out_col       <= s1_col_reg - COL_W'(1);
            m_out_row       <= s1_row_reg - ROW_W'(1);
            m_last_of_frame <= s1_last_reg;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // a blocked stage 1 request keeps its position
    a_s1_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && !s1_advance |=> s1_valid_reg && $stable(s1_col_reg)
            && $stable(s1_row_reg))
        else $error("stage 1 request lost while blocked");

    // an accepted pixel always occupies stage 1 next cycle
    a_accept_s1: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> s1_valid_reg)
        else $error("accepted pixel missing from stage 1");

    // only interior centers leave the block
    a_interior: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_advance && s1_emit_reg |-> s1_col_reg >= COL_W'(2)
            && s1_row_reg >= ROW_W'(2))
        else $error("border position emitted");

endmodule
`default_nettype wire

// ===== bench/gb3_result_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gb3_result_checker: predicts and checks the 3x3 Gaussian blur core
// Watches the pixel, result and register channels, keeps its own copy of the
// line stores, window and position, and checks every accepted result in order.
// ----------------------------------------------------------------------------
module gb3_result_checker (
    input  wire                          aclk,
    input  wire                          aresetn,
    // pixel request channel
    input  wire                          s_valid,
    input  wire                          s_ready,
    input  wire  [gb3_pkg::PIX_W-1:0]    s_pixel,
    input  wire                          s_frame_start,
    // result channel
    input  wire                          m_valid,
    input  wire                          m_ready,
    input  wire  [gb3_pkg::PIX_W-1:0]    m_filtered,
    input  wire  [gb3_pkg::COL_W-1:0]    m_out_col,
    input  wire  [gb3_pkg::ROW_W-1:0]    m_out_row,
    input  wire                          m_last_of_frame,
    // register port
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire  [gb3_pkg::APB_AW-1:0]   paddr,
    input  wire  [gb3_pkg::APB_DW-1:0]   pwdata,
    input  wire  [gb3_pkg::APB_DW-1:0]   prdata,
    input  wire                          pready,
    // status to the bench top
    output int                           mismatch_count,
    output int                           outstanding
);
    import gb3_pkg::*;

    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [PIX_W-1:0] filtered;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             last;
    } blur_result_t;

    blur_result_t     expected_blurs[$];
    bit [PIX_W-1:0]   upper_line [MAX_WIDTH];
    bit [PIX_W-1:0]   middle_line [MAX_WIDTH];
    // taps 0..2: column c-2, taps 3..5: column c-1, each top, middle, bottom
    bit [PIX_W-1:0]   taps [6];
    int unsigned      col_pos;
    int unsigned      row_pos;
    logic [FW_W-1:0]  width_reg;
    logic [FH_W-1:0]  height_reg;

    initial begin
        mismatch_count = 0;
        outstanding    = 0;
    end

    function automatic int unsigned clamp_range(input int unsigned v, input int unsigned lo,
                                                input int unsigned hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic void note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) $display("mismatch: %s", msg);
    endfunction

    // Advance the position for one pixel and queue the blur it completes
    function automatic void blur_pixel(input logic [PIX_W-1:0] px, input logic fs);
        int unsigned  w;
        int unsigned  h;
        int unsigned  c;
        int unsigned  r;
        int unsigned  sum;
        bit [PIX_W-1:0] top;
        bit [PIX_W-1:0] mid;
        blur_result_t res;
        w = clamp_range(width_reg, 3, MAX_WIDTH);
        h = clamp_range(height_reg, 3, HEIGHT_LIMIT);
        if (fs) begin
            col_pos = 0;
            row_pos = 0;
        end
        // a shrunk geometry starts a new line or wraps the frame
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
        end
        if (row_pos >= h) row_pos = 0;
        c   = col_pos;
        r   = row_pos;
        top = upper_line[c];
        mid = middle_line[c];
        if (r >= 2 && c >= 2) begin
            sum = taps[0] + 2 * taps[3] + top
                + 2 * taps[1] + 4 * taps[4] + 2 * mid
                + taps[2] + 2 * taps[5] + px;
            res.filtered = PIX_W'(sum >> 4);
            res.col      = COL_W'(c - 1);
            res.row      = ROW_W'(r - 1);
            res.last     = (r == h - 1) && (c == w - 1);
            expected_blurs.push_back(res);
        end
        // shift the window and update the line stores
        taps[0] = taps[3];
        taps[1] = taps[4];
        taps[2] = taps[5];
        taps[3] = top;
        taps[4] = mid;
        taps[5] = px;
        upper_line[c]  = mid;
        middle_line[c] = px;
        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) r = 0;
        end
        col_pos = c;
        row_pos = r;
    endfunction

    // Compare one accepted result against the oldest expectation
    function automatic void check_blur();
        blur_result_t want;
        if (expected_blurs.size() == 0) begin
            note_mismatch($sformatf("unexpected result filtered %0d col %0d row %0d last %0b",
                                    m_filtered, m_out_col, m_out_row, m_last_of_frame));
            return;
        end
        want = expected_blurs.pop_front();
        if (want.filtered !== m_filtered || want.col !== m_out_col ||
            want.row !== m_out_row || want.last !== m_last_of_frame) begin
            note_mismatch($sformatf(
                "expected filtered %0d col %0d row %0d last %0b, got %0d col %0d row %0d last %0b",
                want.filtered, want.col, want.row, want.last,
                m_filtered, m_out_col, m_out_row, m_last_of_frame));
        end
    endfunction

    always @(posedge aclk) begin
        logic [APB_DW-1:0] reg_value;
        if (!aresetn) begin
            width_reg  = FW_RESET;
            height_reg = FH_RESET;
            col_pos    = 0;
            row_pos    = 0;
            foreach (taps[i]) taps[i] = '0;
            expected_blurs.delete();
        end else begin
            // track register writes, check register reads
            if (psel && penable && pready) begin
                if (pwrite) begin
                    if (paddr[2] == REG_FRAME_WIDTH) width_reg = pwdata[FW_W-1:0];
                    else height_reg = pwdata[FH_W-1:0];
                end else begin
                    reg_value = (paddr[2] == REG_FRAME_WIDTH) ? APB_DW'(width_reg)
                                                             : APB_DW'(height_reg);
                    if (prdata !== reg_value) begin
                        note_mismatch($sformatf("register at 0x%0h read 0x%0h, expected 0x%0h",
                                                paddr, prdata, reg_value));
                    end
                end
            end
            if (m_valid && m_ready) check_blur();
            if (s_valid && s_ready) blur_pixel(s_pixel, s_frame_start);
        end
        outstanding <= expected_blurs.size();
    end

endmodule
`default_nettype wire

// ===== bench/tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the 3x3 Gaussian blur core
// Programs frame geometries over the register port, streams raster frames
// with bursty input and a stalling receiver, and lets the checker compare.
// ----------------------------------------------------------------------------
module tb;
    import gb3_pkg::*;

    localparam logic [APB_AW-1:0] ADDR_FRAME_WIDTH  = 3'h0;
    localparam logic [APB_AW-1:0] ADDR_FRAME_HEIGHT = 3'h4;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 200;
    localparam int RANDOM_ITEMS  = 750;
    localparam int TIMEOUT       = 1_000_000;

    typedef enum int {PIX_RANDOM, PIX_EXTREME, PIX_SMOOTH, PIX_WHITE, PIX_BLACK} pix_mode_t;
    typedef enum int {RX_ALWAYS, RX_COIN, RX_RARE, RX_RUNS} rx_mode_t;
    typedef enum int {TX_STREAM, TX_BURSTS} tx_mode_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [PIX_W-1:0]   s_pixel;
    logic               s_frame_start;
    logic               m_valid;
    logic               m_ready;
    logic [PIX_W-1:0]   m_filtered;
    logic [COL_W-1:0]   m_out_col;
    logic [ROW_W-1:0]   m_out_row;
    logic               m_last_of_frame;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [APB_AW-1:0]  paddr;
    logic [APB_DW-1:0]  pwdata;
    logic [APB_DW-1:0]  prdata;
    logic               pready;
    int                 mismatch_count;
    int                 outstanding;

    logic               s_took   = 1'b0;
    logic               apb_took = 1'b0;
    rx_mode_t           rx_mode  = RX_ALWAYS;
    tx_mode_t           tx_mode  = TX_STREAM;
    int                 burst_left   = 0;
    int                 hold_ask     = 0;
    int                 hold_seen    = 0;
    int                 hold_left    = 0;
    int                 run_left     = 0;
    bit                 run_level    = 1'b1;
    int                 active_width = 640;
    int                 random_sent;

    gaussian_blur_3x3_core dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_pixel         (s_pixel),
        .s_frame_start   (s_frame_start),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_filtered      (m_filtered),
        .m_out_col       (m_out_col),
        .m_out_row       (m_out_row),
        .m_last_of_frame (m_last_of_frame),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    gb3_result_checker result_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_pixel         (s_pixel),
        .s_frame_start   (s_frame_start),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_filtered      (m_filtered),
        .m_out_col       (m_out_col),
        .m_out_row       (m_out_row),
        .m_last_of_frame (m_last_of_frame),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .mismatch_count  (mismatch_count),
        .outstanding     (outstanding)
    );

    // Clock, 10 units per period
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Sample handshakes at the rising edge for the falling-edge drivers
    always @(posedge aclk) begin
        s_took   <= s_valid && s_ready;
        apb_took <= psel && penable && pready;
    end

    // Receiver: long hold-off on request, otherwise the current stall pattern
    always @(negedge aclk) begin
        if (hold_ask != hold_seen) begin
            hold_seen = hold_ask;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_COIN: begin
                    m_ready <= 1'($urandom_range(0, 1));
                end
                RX_RARE: begin
                    m_ready <= ($urandom_range(0, 9) != 0);
                end
                RX_RUNS: begin
                    if (run_left == 0) begin
                        run_left  = $urandom_range(1, 8);
                        run_level = 1'($urandom_range(0, 1));
                    end
                    run_left--;
                    m_ready <= run_level;
                end
                default: begin
                    m_ready <= 1'b1;
                end
            endcase
        end
    end

    // Run limit
    initial begin
        #(TIMEOUT);
        $display("Some tests failed");
        $finish;
    end

    function automatic int clamp_width(input int fw);
        if (fw < 3) return 3;
        if (fw > MAX_WIDTH) return MAX_WIDTH;
        return fw;
    endfunction

    function automatic logic [APB_DW-1:0] reg_data(input int val, input bit junk);
        return {junk ? 16'($urandom()) : 16'h0, 16'(val)};
    endfunction

    function automatic logic [PIX_W-1:0] next_pixel(input pix_mode_t m,
                                                    input logic [PIX_W-1:0] prev);
        int step;
        case (m)
            PIX_WHITE:   return 8'hFF;
            PIX_BLACK:   return 8'h00;
            PIX_EXTREME: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            PIX_SMOOTH: begin
                step = $urandom_range(0, 8) - 4;
                return 8'(int'(prev) + step);
            end
            default:     return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // One register access: setup cycle, access until pready, then back to idle
    task automatic apb_access(input logic wr, input logic [APB_AW-1:0] addr,
                              input logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        do @(negedge aclk); while (!apb_took);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
    endtask

    // Offer one pixel request and hold it until accepted
    task automatic push_pixel(input logic [PIX_W-1:0] px, input logic fs);
        int gap;
        if (tx_mode == TX_BURSTS && burst_left == 0) begin
            gap = $urandom_range(1, 6);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
            burst_left = $urandom_range(1, 40);
        end
        if (burst_left > 0) burst_left--;
        s_valid       <= 1'b1;
        s_pixel       <= px;
        s_frame_start <= fs;
        do @(negedge aclk); while (!s_took);
    endtask

    // Drop valid and wait until every queued blur has come out
    task automatic wait_results();
        s_valid <= 1'b0;
        do @(negedge aclk); while (outstanding != 0);
    endtask

    // Reprogram the geometry while idle, then stream count pixels
    task automatic run_phase(input int fw, input int fh, input int count, input pix_mode_t pmode,
                             input bit restart, input bit noise, input bit pause_mid,
                             input bit long_hold);
        logic [PIX_W-1:0] px;
        logic             fs;
        int               new_width;
        wait_results();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        apb_access(1'b1, ADDR_FRAME_WIDTH, reg_data(fw, noise));
        apb_access(1'b1, ADDR_FRAME_HEIGHT, reg_data(fh, noise));
        apb_access(1'b0, ADDR_FRAME_WIDTH, '0);
        apb_access(1'b0, ADDR_FRAME_HEIGHT, '0);
        // a wider line needs a fresh frame so no stale store entry is used
        new_width = clamp_width(fw);
        if (new_width > active_width) restart = 1'b1;
        active_width = new_width;
        if (long_hold) hold_ask++;
        px = 8'd128;
        for (int i = 0; i < count; i++) begin
            if (pause_mid && i == count / 2) wait_results();
            px = next_pixel(pmode, px);
            fs = (i == 0 && restart) || (noise && $urandom_range(0, 79) == 0);
            push_pixel(px, fs);
        end
    endtask

    initial begin
        int        fw;
        int        fh;
        int        n;
        int        sel;
        pix_mode_t pm;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_pixel       = '0;
        s_frame_start = 1'b0;
        m_ready       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: saturated frame, then a black frame of minimum size
        run_phase(4, 4, 16, PIX_WHITE, 1'b1, 1'b0, 1'b0, 1'b0);
        run_phase(3, 3, 9, PIX_BLACK, 1'b1, 1'b0, 1'b0, 1'b0);

        // Fixed geometries with random content
        rx_mode = RX_COIN;
        tx_mode = TX_BURSTS;
        // under-range registers clamp to 3x3; frames wrap without a start mark
        run_phase(0, 2, 40, PIX_RANDOM, 1'b1, 1'b0, 1'b0, 1'b0);
        // stop at row 5, column 6, pausing halfway until drained
        run_phase(10, 8, 57, PIX_SMOOTH, 1'b1, 1'b0, 1'b1, 1'b0);
        // shrink both dimensions mid-frame and carry on
        rx_mode = RX_RUNS;
        run_phase(5, 4, 50, PIX_EXTREME, 1'b0, 1'b0, 1'b0, 1'b0);
        // long receiver hold-off while the sender keeps offering
        rx_mode = RX_ALWAYS;
        tx_mode = TX_STREAM;
        run_phase(6, 5, 300, PIX_RANDOM, 1'b1, 1'b0, 1'b0, 1'b1);
        // over-range width clamps, first row only
        rx_mode = RX_RARE;
        tx_mode = TX_BURSTS;
        run_phase(4095, 3, 60, PIX_RANDOM, 1'b1, 1'b0, 1'b0, 1'b0);
        // over-range height clamps, narrow lines into the interior
        run_phase(3, 8191, 60, PIX_RANDOM, 1'b1, 1'b0, 1'b0, 1'b0);
        // exact upper limits, first row only
        run_phase(MAX_WIDTH, HEIGHT_LIMIT, 40, PIX_RANDOM, 1'b1, 1'b0, 1'b0, 1'b0);

        // Random geometries, mostly small frames, with start-mark noise
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            sel = $urandom_range(0, 9);
            fw  = (sel < 8) ? $urandom_range(3, 12) :
                  (sel == 8) ? $urandom_range(0, 2) : $urandom_range(13, 40);
            sel = $urandom_range(0, 9);
            fh  = (sel < 8) ? $urandom_range(3, 8) :
                  (sel == 8) ? $urandom_range(0, 2) : $urandom_range(9, 20);
            n   = $urandom_range(40, 160);
            pm  = pix_mode_t'($urandom_range(0, 2));
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            tx_mode = tx_mode_t'($urandom_range(0, 1));
            run_phase(fw, fh, n, pm, $urandom_range(0, 4) != 0, 1'b1,
                      $urandom_range(0, 5) == 0, 1'b0);
            random_sent += n;
        end

        // Drain and give the verdict
        wait_results();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (mismatch_count == 0 && outstanding == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
`default_nettype wire
